// ===== sv/crc8fpc_pkg.sv =====
// Shared types, constants and functions of the framed packet checker.
package crc8fpc_pkg;

	localparam logic [7:0] CRC_SEED = 8'h42;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam int unsigned CRC_BITS = 8;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// byte positions inside a packet
	localparam logic [15:0] POS_START0 = 16'd0;
	localparam logic [15:0] POS_START1 = 16'd1;
	localparam logic [15:0] POS_START2 = 16'd2;
	localparam logic [15:0] POS_LEN_HI = 16'd3;
	localparam logic [15:0] POS_LEN_LO = 16'd4;
	localparam logic [15:0] POS_CMD = 16'd5;

	// command codes
	localparam logic [7:0] CMD_SEARCH = 8'h00;
	localparam logic [7:0] CMD_FIRST = 8'h10;
	localparam logic [7:0] CMD_LAST = 8'h15;

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_FIRST  = 2'd0,
		REG_START_SECOND = 2'd1,
		REG_START_THIRD  = 2'd2,
		REG_CHANNEL_MODE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		VERDICT_NONE   = 3'd0,
		VERDICT_SEARCH = 3'd1,
		VERDICT_BASE   = 3'd2
	} verdict_code_t;

	localparam logic MODE_DATAGRAM = 1'b0;
	localparam logic MODE_STREAM = 1'b1;

	typedef struct packed {
		logic [7:0] start_first;
		logic [7:0] start_second;
		logic [7:0] start_third;
		logic       channel_mode;
	} cfg_t;

	// One byte of a reflected CRC-8 update.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < CRC_BITS; k++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	function automatic logic [2:0] classify(input logic mode, input logic [7:0] code);
		logic [7:0] d;
		logic [2:0] res;
		d = code - CMD_FIRST;
		res = VERDICT_NONE;
		if (mode == MODE_DATAGRAM) begin
			if (code == CMD_SEARCH) begin
				res = VERDICT_SEARCH;
			end
		end else if (code inside {[CMD_FIRST:CMD_LAST]}) begin
			res = d[2:0] + VERDICT_BASE;
		end
		return res;
	endfunction

endpackage

// ===== sv/crc8fpc_core.sv =====
// Per-packet state: byte count, running CRC, header match, length and command capture.
module crc8fpc_core
	import crc8fpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  cfg_t       cfg,
	output logic [2:0] verdict
);

	logic [15:0] count_q;
	logic [7:0]  crc_q;
	logic        header_match_q;
	logic [15:0] length_q;
	logic [7:0]  command_q;

	logic [16:0] total;
	logic [7:0]  code;
	logic        count_ok;

	assign total = {1'b0, count_q} + 17'd1;
	assign code = (count_q == POS_CMD) ? data_byte : command_q;
	assign count_ok = (count_q >= POS_CMD) && (count_q != COUNT_MAX);

	always_comb begin
		verdict = VERDICT_NONE;
		if (count_ok && header_match_q && (crc_q == data_byte) && ({1'b0, length_q} == total)) begin
			verdict = classify(cfg.channel_mode, code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= CRC_SEED;
			header_match_q <= 1'b1;
			length_q <= '0;
			command_q <= '0;
		end else if (step) begin
			if (final_byte) begin
				count_q <= '0;
				crc_q <= CRC_SEED;
				header_match_q <= 1'b1;
				length_q <= '0;
				command_q <= '0;
			end else begin
				case (count_q)
					POS_START0: begin
						if (data_byte != cfg.start_first) header_match_q <= 1'b0;
					end
					POS_START1: begin
						if (data_byte != cfg.start_second) header_match_q <= 1'b0;
					end
					POS_START2: begin
						if (data_byte != cfg.start_third) header_match_q <= 1'b0;
					end
					POS_LEN_HI: length_q[15:8] <= data_byte;
					POS_LEN_LO: length_q[7:0] <= data_byte;
					POS_CMD:    command_q <= data_byte;
					default: ;
				endcase
				crc_q <= crc8_step(crc_q, data_byte);
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 16'd1;
				end
			end
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> count_q == '0 && crc_q == CRC_SEED && header_match_q)
		else $error("packet state not cleared after final byte");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step && !final_byte && count_q != COUNT_MAX |=> count_q == $past(count_q) + 16'd1)
		else $error("byte count did not advance");

	a_verdict_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		verdict != VERDICT_NONE |-> header_match_q && count_q >= POS_CMD)
		else $error("verdict given without header match");

endmodule

// ===== sv/crc8_framed_packet_checker_unit.sv =====
// Framed packet checker with reflected CRC-8: top level with byte and result registers.
//
// Bytes of a packet enter on the in channel (data_byte, final_byte) under
// in_valid/in_ready; final_byte marks the CRC byte that closes the packet.
// Each final byte yields exactly one transaction on the out channel carrying
// verdict (0 none, 1 search, 2..7 stream commands); other bytes yield none.
// The cfg channel (cfg_index, cfg_data) sets the three start bytes and the
// channel mode; cfg_ready is always high. Write it only while no packet is
// in flight.
// A byte is registered in stage 1 and processed there; as a final byte leaves
// stage 1, its verdict is captured in the result register and out_valid rises.
// Throughput: one byte per cycle unless a final byte waits behind a held
// verdict; the only feedback loop is the byte count, CRC and capture state,
// updated once per byte.
// When the receiver stalls, the verdict holds in the result register; the
// following non-final bytes keep flowing, and in_ready drops only while a
// second final byte waits behind the held verdict.
// Reset clears the configuration to its defaults (stream mode, start bytes
// zero) and the packet state to an empty packet with CRC seed 0x42.
module crc8_framed_packet_checker_unit
	import crc8fpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           verdict,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       final_s1;
	logic       advance;
	logic       out_valid_q;
	logic [2:0] verdict_q;
	logic [2:0] core_verdict;
	cfg_t       cfg_q;

	// Byte in stage 1 moves on unless it is a final byte blocked by a held verdict.
	assign advance = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign verdict = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first <= '0;
			cfg_q.start_second <= '0;
			cfg_q.start_third <= '0;
			cfg_q.channel_mode <= MODE_STREAM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_FIRST:  cfg_q.start_first <= cfg_data;
				REG_START_SECOND: cfg_q.start_second <= cfg_data;
				REG_START_THIRD:  cfg_q.start_third <= cfg_data;
				REG_CHANNEL_MODE: cfg_q.channel_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			final_s1 <= final_byte;
		end
	end

	crc8fpc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.final_byte (final_s1),
		.cfg        (cfg_q),
		.verdict    (core_verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			verdict_q <= core_verdict;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && final_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked final byte");

	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && final_s1))
		else $error("result produced without a final byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && final_s1))
		else $error("held verdict overwritten");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the CRC-8 framed packet checker.
`timescale 1ns / 100ps

module tb;
	import crc8fpc_pkg::*;

	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned PHASE_BYTES = 180;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} packet_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = 8'h00;
	logic                 final_byte = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           verdict;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = 8'h00;

	packet_byte_t byte_queue[$];
	logic [2:0]   pending_verdicts[$];
	int unsigned  in_idle_max = 0;
	int unsigned  out_idle_max = 0;
	int unsigned  in_gap = 0;
	int unsigned  out_wait = 0;
	int unsigned  err_count = 0;

	// shadow of the checker: configuration and per-packet state
	cfg_t        model_cfg;
	logic [15:0] rx_count;
	logic [7:0]  rx_crc;
	logic        rx_header_ok;
	logic [15:0] rx_length;
	logic [7:0]  rx_command;

	crc8_framed_packet_checker_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reflected CRC-8, one input bit at a time, LSB first.
	function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ b[i]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 7) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		if (model_cfg.channel_mode == MODE_DATAGRAM) begin
			return CMD_SEARCH;
		end
		return CMD_FIRST + 8'($urandom_range(0, 5));
	endfunction

	task automatic restart_packet();
		rx_count = '0;
		rx_crc = CRC_SEED;
		rx_header_ok = 1'b1;
		rx_length = '0;
		rx_command = '0;
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last);
		packet_byte_t item;
		item.data = data;
		item.last = last;
		byte_queue.push_back(item);
	endtask

	// Build a packet of len >= 7 bytes for the current start bytes; damage hits one byte.
	task automatic queue_packet(input int unsigned len, input logic [7:0] code, input bit damage);
		logic [7:0]  body[$];
		logic [7:0]  crc;
		logic [15:0] len_field;
		int unsigned pos;
		len_field = len[15:0];
		body.push_back(model_cfg.start_first);
		body.push_back(model_cfg.start_second);
		body.push_back(model_cfg.start_third);
		body.push_back(len_field[15:8]);
		body.push_back(len_field[7:0]);
		body.push_back(code);
		while (body.size() < len - 1) begin
			body.push_back(8'($urandom_range(0, 255)));
		end
		crc = CRC_SEED;
		foreach (body[i]) begin
			crc = crc_next(crc, body[i]);
		end
		body.push_back(crc);
		if (damage) begin
			pos = $urandom_range(0, len - 1);
			body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
		end
		foreach (body[i]) begin
			push_byte(body[i], i == len - 1);
		end
	endtask

	task automatic queue_noise(input int unsigned len);
		for (int i = 0; i < len; i++) begin
			push_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] third, input logic mode);
		write_reg(REG_START_FIRST, first);
		write_reg(REG_START_SECOND, second);
		write_reg(REG_START_THIRD, third);
		write_reg(REG_CHANNEL_MODE, {7'd0, mode});
	endtask

	// sample between edges so driver and predictor updates have settled
	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || pending_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Predict verdicts from accepted bytes and track register writes.
	always @(posedge clk or negedge arst_n) begin : predict
		logic [2:0] v;
		logic [7:0] code;
		logic [7:0] diff;
		if (!arst_n) begin
			model_cfg.start_first = 8'h00;
			model_cfg.start_second = 8'h00;
			model_cfg.start_third = 8'h00;
			model_cfg.channel_mode = MODE_STREAM;
			restart_packet();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_START_FIRST: model_cfg.start_first = cfg_data;
					REG_START_SECOND: model_cfg.start_second = cfg_data;
					REG_START_THIRD: model_cfg.start_third = cfg_data;
					REG_CHANNEL_MODE: model_cfg.channel_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (!final_byte) begin
					case (rx_count)
						POS_START0: begin
							if (data_byte != model_cfg.start_first) rx_header_ok = 1'b0;
						end
						POS_START1: begin
							if (data_byte != model_cfg.start_second) rx_header_ok = 1'b0;
						end
						POS_START2: begin
							if (data_byte != model_cfg.start_third) rx_header_ok = 1'b0;
						end
						POS_LEN_HI: rx_length[15:8] = data_byte;
						POS_LEN_LO: rx_length[7:0] = data_byte;
						POS_CMD: rx_command = data_byte;
						default: ;
					endcase
					rx_crc = crc_next(rx_crc, data_byte);
					// saturate the count on very long packets
					if (rx_count != COUNT_MAX) rx_count = rx_count + 16'd1;
				end else begin
					v = VERDICT_NONE;
					// a six-byte packet carries its command in the CRC byte
					code = (rx_count == POS_CMD) ? data_byte : rx_command;
					if (rx_count >= POS_CMD && rx_count != COUNT_MAX && rx_header_ok &&
							rx_crc == data_byte && {1'b0, rx_length} == {1'b0, rx_count} + 17'd1) begin
						if (model_cfg.channel_mode == MODE_DATAGRAM) begin
							if (code == CMD_SEARCH) v = VERDICT_SEARCH;
						end else if (code >= CMD_FIRST && code <= CMD_LAST) begin
							diff = code - CMD_FIRST;
							v = VERDICT_BASE + diff[2:0];
						end
					end
					pending_verdicts.push_back(v);
					restart_packet();
				end
			end
		end
	end

	// Byte driver: hold valid until the transaction completes, then idle a drawn count.
	always @(posedge clk or negedge arst_n) begin : drive
		packet_byte_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			final_byte <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (byte_queue.size() != 0) begin
				item = byte_queue.pop_front();
				in_valid <= 1'b1;
				data_byte <= item.data;
				final_byte <= item.last;
				in_gap <= $urandom_range(0, in_idle_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Verdict monitor with receiver stalls.
	always @(posedge clk or negedge arst_n) begin : check
		logic [2:0]  want;
		int unsigned stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
		end else begin
			stall = out_wait;
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					err_count++;
					$display("%0t unexpected verdict: expected none, actual %0d", $time, verdict);
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict !== want) begin
						err_count++;
						$display("%0t verdict mismatch: expected %0d, actual %0d",
							$time, want, verdict);
					end
				end
				stall = $urandom_range(0, out_idle_max);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				out_wait <= stall - 1;
			end else begin
				out_ready <= 1'b1;
				out_wait <= 0;
			end
		end
	end

	initial begin : stimulus
		int unsigned phase_bytes;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  third;
		logic [7:0]  crc;
		third = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: zero start bytes, stream set
		queue_packet(7, CMD_FIRST, 1'b0);
		queue_packet(7, CMD_LAST + 8'h01, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b1);
		wait_idle();

		// pick the third start byte so the CRC over the five header bytes of a six-byte packet equals the search code
		for (int s = 0; s < 256; s++) begin
			crc = crc_next(CRC_SEED, 8'hFF);
			crc = crc_next(crc, 8'h00);
			crc = crc_next(crc, s[7:0]);
			crc = crc_next(crc, 8'h00);
			crc = crc_next(crc, 8'h06);
			if (crc == CMD_SEARCH) third = s[7:0];
		end
		apply_config(8'hFF, 8'h00, third, MODE_DATAGRAM);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(third, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h06, 1'b0);
		push_byte(CMD_SEARCH, 1'b1);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_config(8'h00, 8'h00, 8'h00, MODE_STREAM);
				1: apply_config(8'hFF, 8'hFF, 8'hFF, MODE_DATAGRAM);
				default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), phase[0]);
			endcase
			in_idle_max = (phase == 1 || phase == 3) ? 0 : ((phase == 4) ? 3 : 15);
			out_idle_max = (phase == 1 || phase == 2) ? 0 : ((phase == 4) ? 7 : 15);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 300) :
						$urandom_range(7, 20);
					queue_packet(len, pick_code(), pick >= 65);
				end else begin
					len = (pick < 88) ? $urandom_range(1, 6) : $urandom_range(1, 30);
					queue_noise(len);
				end
				phase_bytes += len;
			end
			wait_idle();
		end

		// length low byte above 0x7F
		in_idle_max = 0;
		queue_packet(200, CMD_LAST, 1'b0);
		wait_idle();

		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== crc8_framed_packet_checker_unit.f =====
sv/crc8fpc_pkg.sv
sv/crc8fpc_core.sv
sv/crc8_framed_packet_checker_unit.sv
sim/tb.sv
